// File: rtl/wdb_pkg.sv
// wdb_pkg: shared types and constants of the wheel drive board command model
// request and response payload structs, command codes, status codes, limits
// no dependencies
package wdb_pkg;

	localparam int unsigned POS_W   = 13;
	localparam int unsigned FORCE_W = 9;
	localparam int unsigned ANALOG_W = 11;

	localparam logic [POS_W-1:0] POS_MAX        = 13'd8191;
	localparam logic [POS_W-1:0] POS_RESET      = 13'd3200;
	localparam logic [POS_W-1:0] POS_HIGH_LIMIT = 13'd5760;
	localparam logic [POS_W-1:0] POS_LOW_LIMIT  = 13'd640;
	localparam logic [POS_W-1:0] TEST_STEP      = 13'd576;
	localparam logic [FORCE_W-1:0] FORCE_ZERO_POINT = 9'd128;

	// analog = floor(pos * 4 / 25) as (pos * 4 * ceil(2^20 / 25)) >> 20
	localparam int unsigned ANALOG_SHIFT = 20;
	localparam logic [15:0] ANALOG_RECIP = 16'd41944;

	localparam logic [1:0] ST_READY    = 2'd0;
	localparam logic [1:0] ST_NOT_INIT = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;

	localparam logic [7:0] CMD_READY     = 8'hFF;
	localparam logic [7:0] CMD_NOT_INIT  = 8'h81;
	localparam logic [7:0] CMD_TEST      = 8'hFC;
	localparam logic [7:0] CMD_MOVE      = 8'h80;
	localparam logic [7:0] CMD_FORCE_A   = 8'h84;
	localparam logic [7:0] CMD_FORCE_B   = 8'h9E;
	localparam logic [7:0] CMD_STEP_A    = 8'hFA;
	localparam logic [7:0] CMD_STEP_B    = 8'hFD;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] command_byte;
		logic [7:0] direction_byte;
		logic [7:0] force_byte;
		logic       length_ok;
	} wdb_req_t;

	typedef struct packed {
		logic [1:0]          response_status;
		logic [ANALOG_W-1:0] analog_value;
		logic                analog_update;
		logic                write_error;
	} wdb_rsp_t;

endpackage

// File: rtl/wdb_req_if.sv
// wdb_req_if: valid/ready channel carrying one command request
// depends on wdb_pkg
interface wdb_req_if import wdb_pkg::*; ();
	logic     valid;
	logic     ready;
	wdb_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/wdb_rsp_if.sv
// wdb_rsp_if: valid/ready channel carrying one response
// depends on wdb_pkg
interface wdb_rsp_if import wdb_pkg::*; ();
	logic     valid;
	logic     ready;
	wdb_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/wheel_drive_board_command_model.sv
// wheel_drive_board_command_model: emulated steering wheel drive board
// depends on wdb_pkg, wdb_req_if, wdb_rsp_if
//
// usage:
// req carries one request per handshake: a status read or a four-byte
// command packet (length_ok flags the packet length). rsp returns exactly
// one response per request, in order: the status after the request, the
// steering analog value floor(position*4/25), an analog update flag and
// a write error flag for packets of the wrong length.
// a request is registered on acceptance, decoded and applied to the wheel
// state as it leaves the request register, and its response is registered
// in the response register at the same time. while rsp takes each response,
// one request per cycle is taken back to back; the single decode stage sets that rate.
// when rsp stalls, the response register holds, the request register
// fills and then req.ready drops until rsp takes the waiting response.
// asynchronous reset arst_n empties both registers and sets the wheel to
// the centre (position 3200, analog 512), zero force, no bounds test and
// status not initialised.
module wheel_drive_board_command_model import wdb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	wdb_req_if.sink    req,
	wdb_rsp_if.source  rsp
);

	wdb_req_t           req_s1;
	logic               valid_s1;
	logic               adv_s1;

	logic [POS_W-1:0]   pos_q;
	logic [FORCE_W-1:0] force_q;
	logic               test_q;
	logic [1:0]         status_q;

	logic               rsp_valid_q;
	wdb_rsp_t           rsp_data_q;

	logic [POS_W-1:0]   pos_nxt;
	logic [FORCE_W-1:0] force_nxt;
	logic               test_nxt;
	logic [1:0]         status_nxt;
	logic               update;
	logic               err;

	logic signed [14:0] move_sum;
	logic [13:0]        step_sum;
	logic [POS_W-1:0]   move_pos;
	logic [POS_W-1:0]   step_pos;
	logic               force_pos;
	logic               stop_hi;
	logic               stop_lo;
	logic [30:0]        analog_prod;

	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// position arithmetic with saturation
	assign move_sum = $signed({2'b00, pos_q}) + $signed({{6{force_q[FORCE_W-1]}}, force_q});
	assign step_sum = {1'b0, pos_q} + {1'b0, TEST_STEP};

	always_comb begin
		if (move_sum < 0) begin
			move_pos = '0;
		end else if (move_sum > $signed({2'b00, POS_MAX})) begin
			move_pos = POS_MAX;
		end else begin
			move_pos = move_sum[POS_W-1:0];
		end
	end

	assign step_pos  = step_sum[13] ? POS_MAX : step_sum[POS_W-1:0];
	assign force_pos = !force_q[FORCE_W-1] && (force_q != '0);
	assign stop_hi   = (pos_q >= POS_HIGH_LIMIT) && force_pos;
	assign stop_lo   = (pos_q <= POS_LOW_LIMIT) && force_q[FORCE_W-1];

	// command decode
	always_comb begin
		pos_nxt    = pos_q;
		force_nxt  = force_q;
		test_nxt   = test_q;
		status_nxt = status_q;
		update     = 1'b0;
		err        = 1'b0;
		if (req_s1.operation == OP_WRITE) begin
			if (!req_s1.length_ok) begin
				err = 1'b1;
			end else begin
				unique case (req_s1.command_byte) inside
					CMD_READY: begin
						status_nxt = ST_READY;
					end
					CMD_NOT_INIT: begin
						status_nxt = ST_NOT_INIT;
					end
					CMD_TEST: begin
						test_nxt = 1'b1;
					end
					CMD_MOVE: begin
						if (req_s1.direction_byte == 8'd0 && req_s1.force_byte == 8'd0) begin
							force_nxt = '0;
						end else if (req_s1.direction_byte == 8'd1
								&& req_s1.force_byte == 8'd1) begin
							if (!stop_hi && !stop_lo) begin
								pos_nxt = move_pos;
								update  = 1'b1;
							end
						end
					end
					CMD_FORCE_A, CMD_FORCE_B: begin
						status_nxt = ST_READY;
						if (req_s1.direction_byte == 8'd1) begin
							force_nxt = FORCE_W'(0) - {1'b0, req_s1.force_byte};
						end else if (req_s1.direction_byte == 8'd0) begin
							force_nxt = FORCE_ZERO_POINT - {1'b0, req_s1.force_byte};
						end
					end
					CMD_STEP_A, CMD_STEP_B: begin
						if (test_q) begin
							pos_nxt = step_pos;
							update  = 1'b1;
							if (step_pos >= POS_HIGH_LIMIT) begin
								test_nxt   = 1'b0;
								status_nxt = ST_READY;
							end else begin
								status_nxt = ST_BUSY;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign analog_prod = 31'({pos_nxt, 2'b00}) * 31'(ANALOG_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			pos_q       <= POS_RESET;
			force_q     <= '0;
			test_q      <= 1'b0;
			status_q    <= ST_NOT_INIT;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
				pos_q       <= pos_nxt;
				force_q     <= force_nxt;
				test_q      <= test_nxt;
				status_q    <= status_nxt;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (adv_s1) begin
			rsp_data_q.response_status <= status_nxt;
			rsp_data_q.analog_value    <= analog_prod[ANALOG_SHIFT +: ANALOG_W];
			rsp_data_q.analog_update   <= update;
			rsp_data_q.write_error     <= err;
		end
	end

endmodule
